// ===== design/bounded_undo_redo_stacks_core_assert.svh =====
// Assertion macros shared by the history block.
`ifndef BOUNDED_UNDO_REDO_STACKS_CORE_ASSERT_SVH
`define BOUNDED_UNDO_REDO_STACKS_CORE_ASSERT_SVH

// Property holds at every clock edge outside reset.
`define BURS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("history assertion failed");

// Consequent holds in the cycle after the antecedent.
`define BURS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("history assertion failed");

`endif

// ===== design/burs_pkg.sv =====
package burs_pkg;

	localparam int HANDLE_W = 16;
	localparam int FIELD7_W = 7;

	localparam logic [FIELD7_W-1:0] LIMIT_RESET = 7'd64;

	localparam logic [1:0] MODE_RECORD = 2'd0;
	localparam logic [1:0] MODE_UNDO   = 2'd1;
	localparam logic [1:0] MODE_REDO   = 2'd2;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FAIL  = 2'd2;

	typedef logic [HANDLE_W-1:0] handle_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_POP,
		OP_CLEAR
	} stk_op_t;

	typedef struct packed {
		stk_op_t op;
		handle_t data;
	} stk_cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		handle_t    entry_handle;
		logic       command_ok;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		handle_t             moved_handle;
		logic [FIELD7_W-1:0] undo_depth;
		logic [FIELD7_W-1:0] redo_depth;
		handle_t             undo_top;
		handle_t             redo_top;
	} rsp_t;

endpackage

// ===== design/burs_cell.sv =====
module burs_cell (
	input  logic              clk,
	input  burs_pkg::stk_op_t op,
	input  burs_pkg::handle_t from_above,
	input  burs_pkg::handle_t from_below,
	output burs_pkg::handle_t q
);

	burs_pkg::handle_t entry_q;

	// push shifts toward the bottom, pop shifts toward the top
	always_ff @(posedge clk) begin
		unique case (op)
			burs_pkg::OP_PUSH:  entry_q <= from_above;
			burs_pkg::OP_POP:   entry_q <= from_below;
			burs_pkg::OP_HOLD:  entry_q <= entry_q;
			burs_pkg::OP_CLEAR: entry_q <= entry_q;
		endcase
	end

	assign q = entry_q;

endmodule

// ===== design/burs_stack.sv =====
module burs_stack #(
	parameter int STACK_DEPTH = 64,
	parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  burs_pkg::stk_cmd_t cmd,
	input  logic [CNT_W-1:0]   limit,
	output logic [CNT_W-1:0]   count,
	output burs_pkg::handle_t  top
);

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

	burs_pkg::handle_t cells [STACK_DEPTH];
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  grown;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		burs_pkg::handle_t above;
		burs_pkg::handle_t below;

		if (i == 0) begin : g_first
			assign above = cmd.data;
		end else begin : g_mid
			assign above = cells[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_last
			assign below = cells[i];
		end else begin : g_inner
			assign below = cells[i+1];
		end

		burs_cell u_cell (
			.clk        (clk),
			.op         (cmd.op),
			.from_above (above),
			.from_below (below),
			.q          (cells[i])
		);
	end

	// a push onto a full row drops the bottom cell, then trim to the limit
	assign grown = (count_q < DEPTH_C) ? count_q + CNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (cmd.op)
				burs_pkg::OP_PUSH:  count_q <= (grown > limit) ? limit : grown;
				burs_pkg::OP_POP:   count_q <= count_q - CNT_W'(1);
				burs_pkg::OP_CLEAR: count_q <= '0;
				burs_pkg::OP_HOLD:  count_q <= count_q;
			endcase
		end
	end

	assign count = count_q;
	assign top   = (count_q == '0) ? '0 : cells[0];

endmodule

// ===== design/bounded_undo_redo_stacks_core.sv =====
// Undo/redo history with two bounded stacks of command handles. One request is
// accepted per cycle unless a held result stalls the input; its result reaches
// the output register in the cycle after acceptance, and a new request is taken
// in the same cycle that the previous result is delivered. Each stack is a row
// of STACK_DEPTH cells that all shift together (toward the bottom on a push,
// toward the top on a pop), so a move between stacks is one shift of both rows
// and the rate is one item per cycle for any depth. Result depths and top handles
// are read live from the stacks, which hold still until the next request is
// accepted. After reset the stacks start empty with no clearing pass. The level
// limit is to be written by the user via cfg_we/cfg_wdata while the block is idle; the block does not enforce it.
`include "bounded_undo_redo_stacks_core_assert.svh"

module bounded_undo_redo_stacks_core #(
	parameter int STACK_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  burs_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output burs_pkg::rsp_t                    rsp,
	input  logic                              cfg_we,
	input  logic [burs_pkg::FIELD7_W-1:0]     cfg_wdata
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W = (CNT_W > burs_pkg::FIELD7_W) ? CNT_W : burs_pkg::FIELD7_W;
	localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(STACK_DEPTH);

	logic [burs_pkg::FIELD7_W-1:0] limit_q;
	logic [CMP_W-1:0]              limit_ext;
	logic [CMP_W-1:0]              eff_ext;
	logic [CNT_W-1:0]              eff_limit;

	logic                rsp_valid_q;
	logic [1:0]          status_q;
	burs_pkg::handle_t   moved_q;

	burs_pkg::stk_cmd_t  undo_cmd;
	burs_pkg::stk_cmd_t  redo_cmd;
	logic [CNT_W-1:0]    undo_count;
	logic [CNT_W-1:0]    redo_count;
	burs_pkg::handle_t   undo_top;
	burs_pkg::handle_t   redo_top;
	logic [CMP_W-1:0]    undo_count_ext;
	logic [CMP_W-1:0]    redo_count_ext;

	logic                accept;
	logic [1:0]          status_d;
	burs_pkg::handle_t   moved_d;

	// a limit above the depth acts as the depth
	assign limit_ext = CMP_W'(limit_q);
	assign eff_ext   = (limit_ext > DEPTH_CMP) ? DEPTH_CMP : limit_ext;
	assign eff_limit = eff_ext[CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= burs_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	always_comb begin
		status_d      = burs_pkg::STATUS_FAIL;
		moved_d       = '0;
		undo_cmd.op   = burs_pkg::OP_HOLD;
		undo_cmd.data = req.entry_handle;
		redo_cmd.op   = burs_pkg::OP_HOLD;
		redo_cmd.data = undo_top;
		if (accept) begin
			priority if (req.mode == burs_pkg::MODE_RECORD) begin
				// a null handle counts as a failed command
				if (req.entry_handle != '0 && req.command_ok) begin
					undo_cmd.op = burs_pkg::OP_PUSH;
					redo_cmd.op = burs_pkg::OP_CLEAR;
					status_d    = burs_pkg::STATUS_DONE;
					moved_d     = req.entry_handle;
				end
			end else if (req.mode == burs_pkg::MODE_UNDO) begin
				if (undo_count == '0) begin
					status_d = burs_pkg::STATUS_EMPTY;
				end else if (req.command_ok) begin
					undo_cmd.op = burs_pkg::OP_POP;
					redo_cmd.op = burs_pkg::OP_PUSH;
					status_d    = burs_pkg::STATUS_DONE;
					moved_d     = undo_top;
				end
			end else if (req.mode == burs_pkg::MODE_REDO) begin
				if (redo_count == '0) begin
					status_d = burs_pkg::STATUS_EMPTY;
				end else if (req.command_ok) begin
					undo_cmd.op   = burs_pkg::OP_PUSH;
					undo_cmd.data = redo_top;
					redo_cmd.op   = burs_pkg::OP_POP;
					status_d      = burs_pkg::STATUS_DONE;
					moved_d       = redo_top;
				end
			end else begin
				status_d = burs_pkg::STATUS_FAIL;
			end
		end
	end

	burs_stack #(
		.STACK_DEPTH (STACK_DEPTH),
		.CNT_W       (CNT_W)
	) u_undo (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (undo_cmd),
		.limit  (eff_limit),
		.count  (undo_count),
		.top    (undo_top)
	);

	burs_stack #(
		.STACK_DEPTH (STACK_DEPTH),
		.CNT_W       (CNT_W)
	) u_redo (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (redo_cmd),
		.limit  (eff_limit),
		.count  (redo_count),
		.top    (redo_top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			moved_q  <= moved_d;
		end
	end

	assign undo_count_ext = CMP_W'(undo_count);
	assign redo_count_ext = CMP_W'(redo_count);

	assign rsp_valid        = rsp_valid_q;
	assign rsp.status       = status_q;
	assign rsp.moved_handle = moved_q;
	assign rsp.undo_depth   = undo_count_ext[burs_pkg::FIELD7_W-1:0];
	assign rsp.redo_depth   = redo_count_ext[burs_pkg::FIELD7_W-1:0];
	assign rsp.undo_top     = undo_top;
	assign rsp.redo_top     = redo_top;

	`BURS_ASSERT_ALWAYS(a_moved_only_on_done, clk, arst_n,
		!rsp_valid_q || status_q == burs_pkg::STATUS_DONE || moved_q == '0)

	`BURS_ASSERT_NEXT(a_record_clears_redo, clk, arst_n,
		accept && req.mode == burs_pkg::MODE_RECORD && req.entry_handle != '0
			&& req.command_ok,
		rsp_valid && rsp.redo_depth == '0 && rsp.status == burs_pkg::STATUS_DONE)

	`BURS_ASSERT_NEXT(a_undo_empty_status, clk, arst_n,
		accept && req.mode == burs_pkg::MODE_UNDO && undo_count == '0,
		rsp_valid && rsp.status == burs_pkg::STATUS_EMPTY && rsp.undo_depth == '0)

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int DEPTH = 64;
	localparam int UNDO_SIDE = 0;
	localparam int REDO_SIDE = 1;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 4;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	burs_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	burs_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [burs_pkg::FIELD7_W-1:0] cfg_wdata = '0;

	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	// shadow history: index 0 is the undo stack, index 1 the redo stack
	burs_pkg::handle_t ring [2][DEPTH];
	int unsigned ring_head [2] = '{0, 0};
	int unsigned ring_count [2] = '{0, 0};
	logic [burs_pkg::FIELD7_W-1:0] level_limit = burs_pkg::LIMIT_RESET;
	burs_pkg::rsp_t pending_outcomes [$];

	bounded_undo_redo_stacks_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	function automatic burs_pkg::handle_t stack_top(input int side);
		if (ring_count[side] == 0)
			return '0;
		return ring[side][(ring_head[side] + DEPTH - 1) % DEPTH];
	endfunction

	function automatic void push_handle(input int side, input burs_pkg::handle_t h);
		int unsigned cap;
		cap = (level_limit > DEPTH) ? DEPTH : level_limit;
		ring[side][ring_head[side]] = h;
		ring_head[side] = (ring_head[side] + 1) % DEPTH;
		if (ring_count[side] < DEPTH)
			ring_count[side]++;
		// trim to the limit, dropping the oldest entries
		if (ring_count[side] > cap)
			ring_count[side] = cap;
	endfunction

	function automatic burs_pkg::rsp_t apply_request(input burs_pkg::req_t item);
		burs_pkg::rsp_t outcome;
		int src;
		int dst;
		burs_pkg::handle_t h;
		outcome = '0;
		outcome.status = burs_pkg::STATUS_FAIL;
		if (item.mode == burs_pkg::MODE_RECORD) begin
			if (item.entry_handle != '0 && item.command_ok) begin
				push_handle(UNDO_SIDE, item.entry_handle);
				ring_count[REDO_SIDE] = 0;
				outcome.status = burs_pkg::STATUS_DONE;
				outcome.moved_handle = item.entry_handle;
			end
		end else if (item.mode != MODE_UNUSED) begin
			src = (item.mode == burs_pkg::MODE_UNDO) ? UNDO_SIDE : REDO_SIDE;
			dst = (src == UNDO_SIDE) ? REDO_SIDE : UNDO_SIDE;
			if (ring_count[src] == 0) begin
				outcome.status = burs_pkg::STATUS_EMPTY;
			end else if (item.command_ok) begin
				h = stack_top(src);
				ring_head[src] = (ring_head[src] + DEPTH - 1) % DEPTH;
				ring_count[src]--;
				push_handle(dst, h);
				outcome.status = burs_pkg::STATUS_DONE;
				outcome.moved_handle = h;
			end
		end
		outcome.undo_depth = ring_count[UNDO_SIDE][burs_pkg::FIELD7_W-1:0];
		outcome.redo_depth = ring_count[REDO_SIDE][burs_pkg::FIELD7_W-1:0];
		outcome.undo_top = stack_top(UNDO_SIDE);
		outcome.redo_top = stack_top(REDO_SIDE);
		return outcome;
	endfunction

	task automatic check_field(input string field,
			input logic [burs_pkg::HANDLE_W-1:0] want,
			input logic [burs_pkg::HANDLE_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t %s expected %h actual %h", $time, field, want, got);
		end
	endtask

	task automatic compare_result(input burs_pkg::rsp_t want, input burs_pkg::rsp_t got);
		check_field("status", want.status, got.status);
		check_field("moved_handle", want.moved_handle, got.moved_handle);
		check_field("undo_depth", want.undo_depth, got.undo_depth);
		check_field("redo_depth", want.redo_depth, got.redo_depth);
		check_field("undo_top", want.undo_top, got.undo_top);
		check_field("redo_top", want.redo_top, got.redo_top);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				level_limit = cfg_wdata;
			if (req_valid && !req_stall)
				pending_outcomes = {pending_outcomes, apply_request(req)};
			if (rsp_valid && !rsp_stall) begin
				if (pending_outcomes.size() == 0) begin
					mismatches++;
					$display("%0t result expected none actual %h", $time, rsp);
				end else begin
					compare_result(pending_outcomes.pop_front(), rsp);
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	function automatic burs_pkg::req_t make_req(input logic [1:0] mode,
			input burs_pkg::handle_t h, input logic ok);
		burs_pkg::req_t item;
		item.mode = mode;
		item.entry_handle = h;
		item.command_ok = ok;
		return item;
	endfunction

	function automatic burs_pkg::req_t random_request();
		burs_pkg::req_t item;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 46)
			item.mode = burs_pkg::MODE_RECORD;
		else if (pick < 72)
			item.mode = burs_pkg::MODE_UNDO;
		else if (pick < 97)
			item.mode = burs_pkg::MODE_REDO;
		else
			item.mode = MODE_UNUSED;
		pick = $urandom_range(99);
		if (pick < 4)
			item.entry_handle = '0;
		else if (pick < 8)
			item.entry_handle = '1;
		else
			item.entry_handle = burs_pkg::handle_t'($urandom);
		item.command_ok = ($urandom_range(99) < 90);
		return item;
	endfunction

	task automatic send_item(input burs_pkg::req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		// hold the item until it is taken
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [burs_pkg::FIELD7_W-1:0] value);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_basic_requests();
		send_idle_pct = 28;
		recv_idle_pct = 75;
		send_item(make_req(burs_pkg::MODE_UNDO, 16'h1111, 1'b1));
		send_item(make_req(burs_pkg::MODE_REDO, 16'h2222, 1'b1));
		send_item(make_req(burs_pkg::MODE_RECORD, 16'h0000, 1'b1));
		send_item(make_req(burs_pkg::MODE_RECORD, 16'hFFFF, 1'b0));
		send_item(make_req(burs_pkg::MODE_RECORD, 16'hFFFF, 1'b1));
		send_item(make_req(burs_pkg::MODE_RECORD, 16'h0001, 1'b1));
		send_item(make_req(MODE_UNUSED, 16'hFFFF, 1'b1));
		send_item(make_req(MODE_UNUSED, 16'h0000, 1'b0));
		send_item(make_req(burs_pkg::MODE_UNDO, 16'h0000, 1'b0));
		send_item(make_req(burs_pkg::MODE_UNDO, 16'hFFFF, 1'b1));
		send_item(make_req(burs_pkg::MODE_REDO, 16'h0000, 1'b0));
		send_item(make_req(burs_pkg::MODE_REDO, 16'h0000, 1'b1));
		send_item(make_req(burs_pkg::MODE_UNDO, 16'h0000, 1'b1));
		send_item(make_req(burs_pkg::MODE_UNDO, 16'h0000, 1'b1));
		send_item(make_req(burs_pkg::MODE_UNDO, 16'h0000, 1'b1));
		send_item(make_req(burs_pkg::MODE_REDO, 16'h0000, 1'b1));
		// a new record empties the redo stack
		send_item(make_req(burs_pkg::MODE_RECORD, 16'hA5A5, 1'b1));
		send_item(make_req(burs_pkg::MODE_REDO, 16'h0000, 1'b1));
		drain();
	endtask

	task automatic test_limit_edges();
		write_limit(7'd0);
		send_item(make_req(burs_pkg::MODE_RECORD, 16'h1234, 1'b1));
		send_item(make_req(burs_pkg::MODE_UNDO, 16'h0000, 1'b1));
		drain();
		write_limit(7'd2);
		send_item(make_req(burs_pkg::MODE_RECORD, 16'h0F0F, 1'b1));
		send_item(make_req(burs_pkg::MODE_RECORD, 16'hF0F0, 1'b1));
		send_item(make_req(burs_pkg::MODE_RECORD, 16'h8001, 1'b1));
		send_item(make_req(burs_pkg::MODE_UNDO, 16'h0000, 1'b1));
		send_item(make_req(burs_pkg::MODE_UNDO, 16'h0000, 1'b1));
		send_item(make_req(burs_pkg::MODE_UNDO, 16'h0000, 1'b1));
		send_item(make_req(burs_pkg::MODE_REDO, 16'h0000, 1'b1));
		drain();
	endtask

	task automatic test_random_traffic(input int count,
			input logic [burs_pkg::FIELD7_W-1:0] limit,
			input int unsigned send_pct, input int unsigned recv_pct);
		drain();
		write_limit(limit);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (count) send_item(random_request());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_requests();
		test_limit_edges();
		test_random_traffic(190, 7'd64, 28, 75);
		// lowered limit while the stacks are deep
		test_random_traffic(90, 7'd3, 75, 28);
		test_random_traffic(30, 7'd0, 75, 28);
		test_random_traffic(30, 7'd1, 75, 28);
		test_random_traffic(210, 7'd127, 0, 0);
		drain();
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
